/* sv/spmb_pkg.sv */
// Package for the scrolling pattern mask blend core: pixel and queue entry
// types, register map, command codes, reset values and the gray weighting.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spmb_pkg;

	// Configuration port geometry
	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned REG_IDX_W  = 3;

	// Register indexes (byte address is 4 * index)
	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_WIDTH  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_HEIGHT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_EFFECT_ALPHA   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RESULT_KEEP    = 3'd5;

	// Register reset values
	localparam logic [11:0] FRAME_WIDTH_RST    = 12'd640;
	localparam logic [11:0] FRAME_HEIGHT_RST   = 12'd480;
	localparam logic [7:0]  PATTERN_WIDTH_RST  = 8'd128;
	localparam logic [7:0]  PATTERN_HEIGHT_RST = 8'd128;
	localparam logic [10:0] EFFECT_ALPHA_RST   = 11'd717;
	localparam logic [10:0] RESULT_KEEP_RST    = 11'd819;

	// Command codes of an input transaction
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// Width of the load index field
	localparam int unsigned INDEX_W = 14;

	typedef struct packed {
		logic [11:0] frame_width;
		logic [11:0] frame_height;
		logic [7:0]  pattern_width;
		logic [7:0]  pattern_height;
		logic [10:0] effect_alpha;
		logic [10:0] result_keep;
	} cfg_regs_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} bgr_t;

	// Classified transaction as it travels from front to back
	typedef struct packed {
		logic is_load;
		logic mask;
		logic frame_end;
		bgr_t cur;
		bgr_t bg;
	} entry_info_t;

	// Luma: (1868 B + 9617 G + 4899 R + 8192) >> 14
	function automatic logic [7:0] gray8(bgr_t p);
		logic [21:0] s;
		s = 22'(p.b) * 22'd1868 + 22'(p.g) * 22'd9617 + 22'(p.r) * 22'd4899 + 22'd8192;
		return s[21:14];
	endfunction

endpackage

`default_nettype wire

/* sv/spmb_if.sv */
// Valid/ready channel interfaces of the scrolling pattern mask blend core:
// the input transaction channel and the composited pixel channel.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface spmb_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [13:0] texel_index;
	logic [7:0]  cur_b;
	logic [7:0]  cur_g;
	logic [7:0]  cur_r;
	logic [7:0]  bg_b;
	logic [7:0]  bg_g;
	logic [7:0]  bg_r;
	logic        mask;

	modport source (
		output valid, command, texel_index, cur_b, cur_g, cur_r, bg_b, bg_g, bg_r, mask,
		input  ready
	);
	modport sink (
		input  valid, command, texel_index, cur_b, cur_g, cur_r, bg_b, bg_g, bg_r, mask,
		output ready
	);
endinterface

interface spmb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_b;
	logic [7:0] out_g;
	logic [7:0] out_r;
	logic       frame_end;

	modport source (
		output valid, out_b, out_g, out_r, frame_end,
		input  ready
	);
	modport sink (
		input  valid, out_b, out_g, out_r, frame_end,
		output ready
	);
endinterface

`default_nettype wire

/* sv/spmb_queue.sv */
// Small register FIFO between the front and back parts of the core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module spmb_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  not_empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* sv/spmb_front.sv */
// Front part: accepts input transactions, tracks raster and pattern position,
// and turns each transaction into a queue entry with its store address.
// Depends on spmb_pkg and spmb_in_if.
`timescale 1ns / 1ps
`default_nettype none

module spmb_front #(
	parameter int unsigned PATTERN_MAX_W = 128,
	parameter int unsigned PATTERN_MAX_H = 128,
	parameter int unsigned MAX_FRAME_DIM = 2048,
	parameter int unsigned ADDR_W        = 14
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	spmb_in_if.sink                     feed,
	input  wire spmb_pkg::cfg_regs_t    cfg,
	input  wire logic                   push_ready,
	output logic                        push_valid,
	output spmb_pkg::entry_info_t       push_info,
	output logic [ADDR_W-1:0]           push_addr
);

	localparam int unsigned STORE_DEPTH = PATTERN_MAX_W * PATTERN_MAX_H;
	localparam int unsigned PXC_W = $clog2(PATTERN_MAX_W);
	localparam int unsigned PXD_W = $clog2(PATTERN_MAX_W + 1);
	localparam int unsigned PYC_W = $clog2(PATTERN_MAX_H);
	localparam int unsigned PYD_W = $clog2(PATTERN_MAX_H + 1);
	localparam int unsigned FC_W  = $clog2(MAX_FRAME_DIM);
	localparam int unsigned FD_W  = $clog2(MAX_FRAME_DIM + 1);

	logic [FD_W-1:0]  fw, fh;
	logic [PXD_W-1:0] pw;
	logic [PYD_W-1:0] ph;

	logic [FC_W-1:0]  col_q, row_q;
	logic [PXC_W-1:0] scroll_x_q, tcol_q;
	logic [PYC_W-1:0] scroll_y_q, trow_q;

	logic             accept, is_load, pix_acc, idx_ok;
	logic             col_last, row_last;
	logic [PXC_W-1:0] tcol_next, sx_next, sx_eff, tcol_start;
	logic [PYC_W-1:0] trow_next, sy_next, trow_start;
	logic [PXD_W-1:0] tcol_inc, sx_inc;
	logic [PYD_W-1:0] trow_inc, sy_inc;
	logic [ADDR_W-1:0] tex_addr;

	// Clamp sizes: zero counts as one, large values saturate
	always_comb begin
		if (cfg.frame_width == '0) fw = FD_W'(1);
		else if (32'(cfg.frame_width) > MAX_FRAME_DIM) fw = FD_W'(MAX_FRAME_DIM);
		else fw = FD_W'(cfg.frame_width);
		if (cfg.frame_height == '0) fh = FD_W'(1);
		else if (32'(cfg.frame_height) > MAX_FRAME_DIM) fh = FD_W'(MAX_FRAME_DIM);
		else fh = FD_W'(cfg.frame_height);
		if (cfg.pattern_width == '0) pw = PXD_W'(1);
		else if (32'(cfg.pattern_width) > PATTERN_MAX_W) pw = PXD_W'(PATTERN_MAX_W);
		else pw = PXD_W'(cfg.pattern_width);
		if (cfg.pattern_height == '0) ph = PYD_W'(1);
		else if (32'(cfg.pattern_height) > PATTERN_MAX_H) ph = PYD_W'(PATTERN_MAX_H);
		else ph = PYD_W'(cfg.pattern_height);
	end

	// Classification
	assign feed.ready = push_ready;
	assign accept     = feed.valid && push_ready;
	assign is_load    = (feed.command == spmb_pkg::CMD_LOAD);
	assign pix_acc    = accept && !is_load;
	assign idx_ok     = (32'(feed.texel_index) < STORE_DEPTH);
	assign push_valid = accept && (!is_load || idx_ok);

	// Raster end detection
	assign col_last = (FD_W'(col_q) + FD_W'(1)) >= fw;
	assign row_last = (FD_W'(row_q) + FD_W'(1)) >= fh;

	// Pattern coordinate stepping with wrap at the pattern size
	always_comb begin
		tcol_inc  = PXD_W'(tcol_q) + PXD_W'(1);
		tcol_next = (tcol_inc >= pw) ? '0 : PXC_W'(tcol_inc);
		trow_inc  = PYD_W'(trow_q) + PYD_W'(1);
		trow_next = (trow_inc >= ph) ? '0 : PYC_W'(trow_inc);
		sx_inc    = PXD_W'(scroll_x_q) + PXD_W'(1);
		sx_next   = (sx_inc >= pw) ? '0 : PXC_W'(sx_inc);
		sy_inc    = PYD_W'(scroll_y_q) + PYD_W'(1);
		sy_next   = (sy_inc >= ph) ? '0 : PYC_W'(sy_inc);
		// start of a row uses the scroll value in effect after this pixel
		sx_eff    = row_last ? sx_next : scroll_x_q;
		if (sx_eff == '0 || PXD_W'(sx_eff) >= pw) tcol_start = '0;
		else tcol_start = PXC_W'(pw - PXD_W'(sx_eff));
		if (sy_next == '0 || PYD_W'(sy_next) >= ph) trow_start = '0;
		else trow_start = PYC_W'(ph - PYD_W'(sy_next));
	end

	assign tex_addr = ADDR_W'(trow_q) * ADDR_W'(PATTERN_MAX_W) + ADDR_W'(tcol_q);

	// Queue entry
	always_comb begin
		push_info.is_load   = is_load;
		push_info.mask      = feed.mask;
		push_info.frame_end = col_last && row_last;
		push_info.cur       = '{r: feed.cur_r, g: feed.cur_g, b: feed.cur_b};
		push_info.bg        = '{r: feed.bg_r, g: feed.bg_g, b: feed.bg_b};
		push_addr           = is_load ? ADDR_W'(feed.texel_index) : tex_addr;
	end

	// Position counters advance on every accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			scroll_x_q <= '0;
			scroll_y_q <= '0;
			tcol_q     <= '0;
			trow_q     <= '0;
		end else if (pix_acc) begin
			if (col_last) begin
				col_q  <= '0;
				tcol_q <= tcol_start;
				if (row_last) begin
					row_q      <= '0;
					scroll_x_q <= sx_next;
					scroll_y_q <= sy_next;
					trow_q     <= trow_start;
				end else begin
					row_q  <= row_q + FC_W'(1);
					trow_q <= trow_next;
				end
			end else begin
				col_q  <= col_q + FC_W'(1);
				tcol_q <= tcol_next;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/spmb_back.sv */
// Back part: pattern store, gray conversion and the two blends, run as a
// stall-as-one pipeline that ends in the output register.
// Depends on spmb_pkg and spmb_out_if.
`timescale 1ns / 1ps
`default_nettype none

module spmb_back #(
	parameter int unsigned STORE_DEPTH      = 16384,
	parameter int unsigned ADDR_W           = 14,
	parameter int unsigned WEIGHT_FRAC_BITS = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire spmb_pkg::cfg_regs_t   cfg,
	input  wire logic                  pop_valid,
	input  wire spmb_pkg::entry_info_t pop_info,
	input  wire logic [ADDR_W-1:0]     pop_addr,
	output logic                       pop,
	spmb_out_if.source                 result
);

	localparam int unsigned ONE = 1 << WEIGHT_FRAC_BITS;
	localparam int unsigned WW  = WEIGHT_FRAC_BITS + 1;
	localparam int unsigned SW  = WEIGHT_FRAC_BITS + 10;
	localparam logic [WW-1:0] ONE_W = WW'(ONE);
	localparam logic [SW-1:0] HALF  = SW'(ONE / 2);

	spmb_pkg::bgr_t mem [STORE_DEPTH];

	logic           advance;
	logic [WW-1:0]  w_alpha, w_keep;
	logic           v1_s1, v2_s2, v3_s3, out_valid_q;

	spmb_pkg::bgr_t texel_s1, cur_s1, bg_s1;
	logic           mask_s1, fe_s1;
	spmb_pkg::bgr_t texel_s2, bg_s2;
	logic [7:0]     gray_s2;
	logic           mask_s2, fe_s2;
	spmb_pkg::bgr_t eff_s3, bg_s3;
	logic           fe_s3;
	spmb_pkg::bgr_t out_q;
	logic           fe_q;

	// Q weight blend; a convex mix never exceeds 255
	function automatic logic [7:0] blend8(logic [7:0] a, logic [7:0] b, logic [WW-1:0] w);
		logic [SW-1:0] s;
		s = SW'(a) * SW'(w) + SW'(b) * SW'(ONE_W - w) + HALF;
		return s[WEIGHT_FRAC_BITS +: 8];
	endfunction

	// Saturate weights to one
	assign w_alpha = (32'(cfg.effect_alpha) > ONE) ? ONE_W : WW'(cfg.effect_alpha);
	assign w_keep  = (32'(cfg.result_keep) > ONE) ? ONE_W : WW'(cfg.result_keep);

	// Whole pipe moves unless the output register is held
	assign advance = !out_valid_q || result.ready;
	assign pop     = pop_valid && advance;

	// Pattern store: loads write, pixels read
	always_ff @(posedge clk) begin
		if (pop && pop_info.is_load) begin
			mem[pop_addr] <= pop_info.cur;
		end
		if (pop && !pop_info.is_load) begin
			texel_s1 <= mem[pop_addr];
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v1_s1       <= pop && !pop_info.is_load;
			v2_s2       <= v1_s1;
			v3_s3       <= v2_s2;
			out_valid_q <= v3_s3;
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		if (advance) begin
			// s1: side data alongside the store read
			cur_s1  <= pop_info.cur;
			bg_s1   <= pop_info.bg;
			mask_s1 <= pop_info.mask;
			fe_s1   <= pop_info.frame_end;
			// s2: gray of the current pixel
			gray_s2  <= spmb_pkg::gray8(cur_s1);
			texel_s2 <= texel_s1;
			bg_s2    <= bg_s1;
			mask_s2  <= mask_s1;
			fe_s2    <= fe_s1;
			// s3: effect blend, masked against background
			if (mask_s2) begin
				eff_s3.b <= blend8(texel_s2.b, gray_s2, w_alpha);
				eff_s3.g <= blend8(texel_s2.g, gray_s2, w_alpha);
				eff_s3.r <= blend8(texel_s2.r, gray_s2, w_alpha);
			end else begin
				eff_s3 <= bg_s2;
			end
			bg_s3 <= bg_s2;
			fe_s3 <= fe_s2;
			// output: keep blend against background
			out_q.b <= blend8(eff_s3.b, bg_s3.b, w_keep);
			out_q.g <= blend8(eff_s3.g, bg_s3.g, w_keep);
			out_q.r <= blend8(eff_s3.r, bg_s3.r, w_keep);
			fe_q    <= fe_s3;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_b     = out_q.b;
	assign result.out_g     = out_q.g;
	assign result.out_r     = out_q.r;
	assign result.frame_end = fe_q;

endmodule

`default_nettype wire

/* sv/scrolling_pattern_mask_blend_core.sv */
// Top level of the scrolling pattern mask blend core: configuration
// registers, front part, entry queue and back part.
// Depends on spmb_pkg, spmb_if, spmb_queue, spmb_front and spmb_back.
//
//   channel  dir  handshake            payload
//   feed     in   valid/ready          command, texel_index, cur_bgr, bg_bgr, mask
//   result   out  valid/ready          out_bgr, frame_end
//   apb      in   psel/penable/pready  paddr, pwdata, prdata (registers at 4*i)
//
// One transaction is taken per cycle while the two-entry queue has room.
// A pixel passes through the queue, the store read, gray, the effect blend and
// the keep blend into the output register before it shows up on result;
// a load writes the pattern store when it leaves the queue and yields nothing.
// The back pipeline stalls as a whole when result is held; the queue then
// fills and drops feed.ready. Reset loads register defaults and clears the
// counters; the pattern store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module scrolling_pattern_mask_blend_core #(
	parameter int unsigned PATTERN_MAX_W    = 128,
	parameter int unsigned PATTERN_MAX_H    = 128,
	parameter int unsigned MAX_FRAME_DIM    = 2048,
	parameter int unsigned WEIGHT_FRAC_BITS = 10
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	spmb_in_if.sink                              feed,
	spmb_out_if.source                           result,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [spmb_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [spmb_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [spmb_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready
);

	localparam int unsigned STORE_DEPTH = PATTERN_MAX_W * PATTERN_MAX_H;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
	localparam int unsigned ENTRY_W     = ADDR_W + $bits(spmb_pkg::entry_info_t);
	localparam int unsigned Q_DEPTH     = 2;

	spmb_pkg::cfg_regs_t             cfg_q;
	logic [spmb_pkg::REG_IDX_W-1:0]  reg_idx;
	logic                            cfg_wr;

	logic                  q_push, q_pop, q_full, q_not_empty;
	spmb_pkg::entry_info_t push_info, pop_info;
	logic [ADDR_W-1:0]     push_addr, pop_addr;
	logic [ENTRY_W-1:0]    q_rd_data;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[spmb_pkg::APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width    <= spmb_pkg::FRAME_WIDTH_RST;
			cfg_q.frame_height   <= spmb_pkg::FRAME_HEIGHT_RST;
			cfg_q.pattern_width  <= spmb_pkg::PATTERN_WIDTH_RST;
			cfg_q.pattern_height <= spmb_pkg::PATTERN_HEIGHT_RST;
			cfg_q.effect_alpha   <= spmb_pkg::EFFECT_ALPHA_RST;
			cfg_q.result_keep    <= spmb_pkg::RESULT_KEEP_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				spmb_pkg::REG_FRAME_WIDTH:    cfg_q.frame_width    <= pwdata[11:0];
				spmb_pkg::REG_FRAME_HEIGHT:   cfg_q.frame_height   <= pwdata[11:0];
				spmb_pkg::REG_PATTERN_WIDTH:  cfg_q.pattern_width  <= pwdata[7:0];
				spmb_pkg::REG_PATTERN_HEIGHT: cfg_q.pattern_height <= pwdata[7:0];
				spmb_pkg::REG_EFFECT_ALPHA:   cfg_q.effect_alpha   <= pwdata[10:0];
				spmb_pkg::REG_RESULT_KEEP:    cfg_q.result_keep    <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (reg_idx)
			spmb_pkg::REG_FRAME_WIDTH:    prdata = 32'(cfg_q.frame_width);
			spmb_pkg::REG_FRAME_HEIGHT:   prdata = 32'(cfg_q.frame_height);
			spmb_pkg::REG_PATTERN_WIDTH:  prdata = 32'(cfg_q.pattern_width);
			spmb_pkg::REG_PATTERN_HEIGHT: prdata = 32'(cfg_q.pattern_height);
			spmb_pkg::REG_EFFECT_ALPHA:   prdata = 32'(cfg_q.effect_alpha);
			spmb_pkg::REG_RESULT_KEEP:    prdata = 32'(cfg_q.result_keep);
			default:                      prdata = '0;
		endcase
	end

	// Front: accept and classify
	spmb_front #(
		.PATTERN_MAX_W (PATTERN_MAX_W),
		.PATTERN_MAX_H (PATTERN_MAX_H),
		.MAX_FRAME_DIM (MAX_FRAME_DIM),
		.ADDR_W        (ADDR_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed       (feed),
		.cfg        (cfg_q),
		.push_ready (!q_full),
		.push_valid (q_push),
		.push_info  (push_info),
		.push_addr  (push_addr)
	);

	// Entry queue
	spmb_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_data   ({push_info, push_addr}),
		.pop       (q_pop),
		.rd_data   (q_rd_data),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	assign pop_info = spmb_pkg::entry_info_t'(q_rd_data[ENTRY_W-1:ADDR_W]);
	assign pop_addr = q_rd_data[ADDR_W-1:0];

	// Back: store, gray, blends
	spmb_back #(
		.STORE_DEPTH      (STORE_DEPTH),
		.ADDR_W           (ADDR_W),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (q_not_empty),
		.pop_info  (pop_info),
		.pop_addr  (pop_addr),
		.pop       (q_pop),
		.result    (result)
	);

	// Checks
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("entry pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty)
		else $error("entry popped from an empty queue");

	a_no_pop_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |-> !q_pop)
		else $error("back part took an entry while the result was held");

	a_accept_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(feed.valid && feed.ready && feed.command == spmb_pkg::CMD_PIXEL) |-> q_push)
		else $error("accepted pixel did not enter the queue");

endmodule

`default_nettype wire

/* dv/tb.sv */
// Testbench for scrolling_pattern_mask_blend_core: directed and random
// texel loads and raster pixels, checked against a cycle-free predictor.
// Depends on spmb_pkg, spmb_if and the core RTL.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned PAT_COLS   = 128;
	localparam int unsigned PAT_ROWS   = 128;
	localparam int unsigned STORE_SIZE = PAT_COLS * PAT_ROWS;
	localparam int unsigned FRAME_MAX  = 2048;
	localparam int unsigned W_ONE      = 1024;
	localparam int unsigned DRAIN_WAIT = 8;
	localparam int unsigned HOLD_LEN   = 150;

	// One input transaction
	typedef struct {
		logic        command;
		logic [13:0] texel_index;
		logic [7:0]  cur_b, cur_g, cur_r;
		logic [7:0]  bg_b, bg_g, bg_r;
		logic        mask;
	} feed_item_t;

	// One composited pixel
	typedef struct {
		logic [7:0] out_b, out_g, out_r;
		logic       frame_end;
	} blend_pixel_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [spmb_pkg::APB_ADDR_W-1:0] paddr;
	logic [spmb_pkg::APB_DATA_W-1:0] pwdata, prdata;

	spmb_in_if  feed_if ();
	spmb_out_if res_if ();

	scrolling_pattern_mask_blend_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.feed    (feed_if),
		.result  (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predictor state: register copy, pattern store and raster counters
	spmb_pkg::cfg_regs_t cfg_copy;
	logic [23:0]  pattern_mem [0:STORE_SIZE-1];
	bit           texel_loaded [0:STORE_SIZE-1];
	int unsigned  scroll_x, scroll_y, col_cnt, row_cnt, tex_col, tex_row;
	blend_pixel_t awaited_pixels [$];

	int  n_errors;
	bit  quiet;
	int  hold_reqs;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned lim);
		if (v == 0) return 1;
		return (v > lim) ? lim : v;
	endfunction

	function automatic logic [10:0] clamp_weight(logic [10:0] w);
		return (w > 11'(W_ONE)) ? 11'(W_ONE) : w;
	endfunction

	function automatic int unsigned step_wrap(int unsigned v, int unsigned size);
		return (v + 1 >= size) ? 0 : v + 1;
	endfunction

	// Texel coordinate at the start of a row or frame for a given scroll
	function automatic int unsigned scroll_origin(int unsigned s, int unsigned size);
		return (s == 0 || s >= size) ? 0 : size - s;
	endfunction

	// Q10 blend with rounding, a carries weight w
	function automatic logic [7:0] mix_q10(logic [7:0] a, logic [7:0] b, logic [10:0] w);
		logic [19:0] acc;
		acc = 20'(a) * 20'(w) + 20'(b) * 20'(11'(W_ONE) - w) + 20'd512;
		return (acc[19:10] > 10'd255) ? 8'hFF : acc[17:10];
	endfunction

	function automatic int unsigned texel_addr();
		int unsigned c, r;
		c = (tex_col < PAT_COLS) ? tex_col : 0;
		r = (tex_row < PAT_ROWS) ? tex_row : 0;
		return r * PAT_COLS + c;
	endfunction

	task automatic predict_transaction(feed_item_t it);
		int unsigned  fw, fh, pw, ph;
		logic [10:0]  wa, wk;
		logic [23:0]  tex;
		logic [21:0]  luma;
		logic [7:0]   gray, pb, pg, pr;
		blend_pixel_t px;
		if (it.command == spmb_pkg::CMD_LOAD) begin
			pattern_mem[it.texel_index]  = {it.cur_r, it.cur_g, it.cur_b};
			texel_loaded[it.texel_index] = 1'b1;
			return;
		end
		fw = clamp_dim(cfg_copy.frame_width, FRAME_MAX);
		fh = clamp_dim(cfg_copy.frame_height, FRAME_MAX);
		pw = clamp_dim(cfg_copy.pattern_width, PAT_COLS);
		ph = clamp_dim(cfg_copy.pattern_height, PAT_ROWS);
		wa = clamp_weight(cfg_copy.effect_alpha);
		wk = clamp_weight(cfg_copy.result_keep);
		tex = pattern_mem[texel_addr()];
		luma = 22'(it.cur_b) * 22'd1868 + 22'(it.cur_g) * 22'd9617
			+ 22'(it.cur_r) * 22'd4899 + 22'd8192;
		gray = luma[21:14];
		if (it.mask) begin
			pb = mix_q10(tex[7:0], gray, wa);
			pg = mix_q10(tex[15:8], gray, wa);
			pr = mix_q10(tex[23:16], gray, wa);
		end else begin
			pb = it.bg_b;
			pg = it.bg_g;
			pr = it.bg_r;
		end
		px.out_b = mix_q10(pb, it.bg_b, wk);
		px.out_g = mix_q10(pg, it.bg_g, wk);
		px.out_r = mix_q10(pr, it.bg_r, wk);
		px.frame_end = 1'b0;
		// raster and pattern position
		if (col_cnt + 1 >= fw) begin
			col_cnt = 0;
			if (row_cnt + 1 >= fh) begin
				px.frame_end = 1'b1;
				row_cnt  = 0;
				scroll_x = step_wrap(scroll_x, pw);
				scroll_y = step_wrap(scroll_y, ph);
				tex_row  = scroll_origin(scroll_y, ph);
			end else begin
				row_cnt++;
				tex_row = step_wrap(tex_row, ph);
			end
			tex_col = scroll_origin(scroll_x, pw);
		end else begin
			col_cnt++;
			tex_col = step_wrap(tex_col, pw);
		end
		awaited_pixels.push_back(px);
	endtask

	// ---------------------------------------------------------------- result side

	// Receiver: random stalls, quiet stretches and long holds on request
	initial begin : result_ready_drv
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= quiet || ($urandom_range(99) >= 36);
			end
		end
	end

	// Compare each accepted pixel against the oldest prediction
	always @(posedge clk) begin : pixel_check
		blend_pixel_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (awaited_pixels.size() == 0) begin
				$error("unexpected pixel: b=%0d g=%0d r=%0d frame_end=%0d",
					res_if.out_b, res_if.out_g, res_if.out_r, res_if.frame_end);
				n_errors++;
			end else begin
				want = awaited_pixels.pop_front();
				if (res_if.out_b !== want.out_b) begin
					$error("out_b: expected %0d, got %0d", want.out_b, res_if.out_b);
					n_errors++;
				end
				if (res_if.out_g !== want.out_g) begin
					$error("out_g: expected %0d, got %0d", want.out_g, res_if.out_g);
					n_errors++;
				end
				if (res_if.out_r !== want.out_r) begin
					$error("out_r: expected %0d, got %0d", want.out_r, res_if.out_r);
					n_errors++;
				end
				if (res_if.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0d, got %0d",
						want.frame_end, res_if.frame_end);
					n_errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- feed side

	// Offer one transaction, optionally after random idle cycles
	task automatic send_item(feed_item_t it);
		if (!quiet) begin
			while ($urandom_range(99) < 36) begin
				feed_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		feed_if.valid       <= 1'b1;
		feed_if.command     <= it.command;
		feed_if.texel_index <= it.texel_index;
		feed_if.cur_b       <= it.cur_b;
		feed_if.cur_g       <= it.cur_g;
		feed_if.cur_r       <= it.cur_r;
		feed_if.bg_b        <= it.bg_b;
		feed_if.bg_g        <= it.bg_g;
		feed_if.bg_r        <= it.bg_r;
		feed_if.mask        <= it.mask;
		do @(posedge clk); while (feed_if.ready !== 1'b1);
		predict_transaction(it);
	endtask

	function automatic feed_item_t random_item(logic cmd);
		feed_item_t it;
		it.command     = cmd;
		it.texel_index = 14'($urandom);
		it.cur_b       = 8'($urandom);
		it.cur_g       = 8'($urandom);
		it.cur_r       = 8'($urandom);
		it.bg_b        = 8'($urandom);
		it.bg_g        = 8'($urandom);
		it.bg_r        = 8'($urandom);
		it.mask        = 1'($urandom);
		return it;
	endfunction

	task automatic send_load(int unsigned idx, logic [23:0] texel);
		feed_item_t it;
		it = random_item(spmb_pkg::CMD_LOAD);
		it.texel_index = 14'(idx);
		{it.cur_r, it.cur_g, it.cur_b} = texel;
		send_item(it);
	endtask

	// A pixel never reads an unwritten texel: load it first if needed
	task automatic send_pixel(feed_item_t it);
		int unsigned addr;
		addr = texel_addr();
		if (!texel_loaded[addr])
			send_load(addr, 24'($urandom));
		send_item(it);
	endtask

	function automatic feed_item_t make_pixel(logic [23:0] cur, logic [23:0] bg, logic m);
		feed_item_t it;
		it = random_item(spmb_pkg::CMD_PIXEL);
		{it.cur_r, it.cur_g, it.cur_b} = cur;
		{it.bg_r, it.bg_g, it.bg_b}    = bg;
		it.mask = m;
		return it;
	endfunction

	// Mostly pixels with random content, some stray loads anywhere in the store
	task automatic send_random_mix(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 12)
				send_item(random_item(spmb_pkg::CMD_LOAD));
			else
				send_pixel(random_item(spmb_pkg::CMD_PIXEL));
		end
	endtask

	// Stop feeding and let every pending pixel and load leave the core
	task automatic wait_idle();
		feed_if.valid <= 1'b0;
		while (awaited_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- register port

	task automatic set_reg(logic [spmb_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= spmb_pkg::APB_ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			spmb_pkg::REG_FRAME_WIDTH:    cfg_copy.frame_width    = value[11:0];
			spmb_pkg::REG_FRAME_HEIGHT:   cfg_copy.frame_height   = value[11:0];
			spmb_pkg::REG_PATTERN_WIDTH:  cfg_copy.pattern_width  = value[7:0];
			spmb_pkg::REG_PATTERN_HEIGHT: cfg_copy.pattern_height = value[7:0];
			spmb_pkg::REG_EFFECT_ALPHA:   cfg_copy.effect_alpha   = value[10:0];
			spmb_pkg::REG_RESULT_KEEP:    cfg_copy.result_keep    = value[10:0];
			default: ;
		endcase
	endtask

	task automatic check_reg(logic [spmb_pkg::REG_IDX_W-1:0] idx, logic [31:0] want,
			string name);
		logic [31:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= spmb_pkg::APB_ADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	// Mostly a typical range, sometimes one of the two extremes
	function automatic logic [31:0] pick_value(int lo_ext, int hi_ext, int lo, int hi);
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0) return lo_ext;
		if (r == 1) return hi_ext;
		return $urandom_range(hi, lo);
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_reset_values();
		check_reg(spmb_pkg::REG_FRAME_WIDTH,
			32'(spmb_pkg::FRAME_WIDTH_RST), "frame_width");
		check_reg(spmb_pkg::REG_FRAME_HEIGHT,
			32'(spmb_pkg::FRAME_HEIGHT_RST), "frame_height");
		check_reg(spmb_pkg::REG_PATTERN_WIDTH,
			32'(spmb_pkg::PATTERN_WIDTH_RST), "pattern_width");
		check_reg(spmb_pkg::REG_PATTERN_HEIGHT,
			32'(spmb_pkg::PATTERN_HEIGHT_RST), "pattern_height");
		check_reg(spmb_pkg::REG_EFFECT_ALPHA,
			32'(spmb_pkg::EFFECT_ALPHA_RST), "effect_alpha");
		check_reg(spmb_pkg::REG_RESULT_KEEP,
			32'(spmb_pkg::RESULT_KEEP_RST), "result_keep");
	endtask

	task automatic test_directed_cases();
		wait_idle();
		set_reg(spmb_pkg::REG_FRAME_WIDTH, 3);
		set_reg(spmb_pkg::REG_FRAME_HEIGHT, 2);
		set_reg(spmb_pkg::REG_PATTERN_WIDTH, 2);
		set_reg(spmb_pkg::REG_PATTERN_HEIGHT, 2);
		set_reg(spmb_pkg::REG_EFFECT_ALPHA, W_ONE);
		set_reg(spmb_pkg::REG_RESULT_KEEP, W_ONE);
		// texel extremes, both ends of the store
		send_load(0, 24'hFFFFFF);
		send_load(1, 24'h000000);
		send_load(STORE_SIZE - 1, 24'hFFFFFF);
		send_load(PAT_COLS, 24'($urandom));
		// pixel extremes with mask on and off; six pixels end the frame
		send_pixel(make_pixel(24'h000000, 24'hFFFFFF, 1'b1));
		send_pixel(make_pixel(24'hFFFFFF, 24'h000000, 1'b1));
		send_pixel(make_pixel(24'hFFFFFF, 24'h000000, 1'b0));
		send_pixel(make_pixel(24'h000000, 24'h000000, 1'b0));
		send_pixel(make_pixel(24'hFFFFFF, 24'hFFFFFF, 1'b1));
		send_pixel(make_pixel(24'($urandom), 24'($urandom), 1'b1));
		// zero weights
		wait_idle();
		set_reg(spmb_pkg::REG_EFFECT_ALPHA, 0);
		set_reg(spmb_pkg::REG_RESULT_KEEP, 0);
		send_pixel(make_pixel(24'($urandom), 24'($urandom), 1'b1));
		send_pixel(make_pixel(24'($urandom), 24'($urandom), 1'b0));
		send_pixel(make_pixel(24'($urandom), 24'($urandom), 1'b1));
		// weights above one, zero sizes count as one
		wait_idle();
		set_reg(spmb_pkg::REG_EFFECT_ALPHA, 2047);
		set_reg(spmb_pkg::REG_RESULT_KEEP, 2047);
		set_reg(spmb_pkg::REG_FRAME_WIDTH, 0);
		set_reg(spmb_pkg::REG_FRAME_HEIGHT, 0);
		set_reg(spmb_pkg::REG_PATTERN_WIDTH, 0);
		set_reg(spmb_pkg::REG_PATTERN_HEIGHT, 0);
		send_pixel(make_pixel(24'($urandom), 24'($urandom), 1'b1));
		send_pixel(make_pixel(24'($urandom), 24'($urandom), 1'b1));
		send_pixel(make_pixel(24'($urandom), 24'($urandom), 1'b0));
		// oversized frame and pattern saturate; counters carry over
		wait_idle();
		set_reg(spmb_pkg::REG_FRAME_WIDTH, 4095);
		set_reg(spmb_pkg::REG_FRAME_HEIGHT, 4095);
		set_reg(spmb_pkg::REG_PATTERN_WIDTH, 255);
		set_reg(spmb_pkg::REG_PATTERN_HEIGHT, 255);
		send_pixel(make_pixel(24'($urandom), 24'($urandom), 1'b1));
		send_pixel(make_pixel(24'($urandom), 24'($urandom), 1'b1));
		send_pixel(make_pixel(24'($urandom), 24'($urandom), 1'b1));
	endtask

	// Reconfigure mid-frame with small frames so scrolls wrap often
	task automatic test_random_phases();
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			set_reg(spmb_pkg::REG_FRAME_WIDTH,    pick_value(0, 4095, 1, 9));
			set_reg(spmb_pkg::REG_FRAME_HEIGHT,   pick_value(0, 4095, 1, 5));
			set_reg(spmb_pkg::REG_PATTERN_WIDTH,  pick_value(0, 255, 1, 8));
			set_reg(spmb_pkg::REG_PATTERN_HEIGHT, pick_value(0, 255, 1, 8));
			set_reg(spmb_pkg::REG_EFFECT_ALPHA,   pick_value(0, 2047, 0, W_ONE));
			set_reg(spmb_pkg::REG_RESULT_KEEP,    pick_value(0, 2047, 0, W_ONE));
			send_random_mix(40);
		end
	endtask

	// Full rate on both sides
	task automatic test_quiet_stretch();
		quiet = 1'b1;
		send_random_mix(60);
		quiet = 1'b0;
	endtask

	// Long receiver hold while the sender keeps offering
	task automatic test_backpressure();
		quiet = 1'b1;
		hold_reqs++;
		send_random_mix(40);
		quiet = 1'b0;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		n_errors  = 0;
		quiet     = 1'b0;
		hold_reqs = 0;
		scroll_x  = 0;
		scroll_y  = 0;
		col_cnt   = 0;
		row_cnt   = 0;
		tex_col   = 0;
		tex_row   = 0;
		cfg_copy  = '{spmb_pkg::FRAME_WIDTH_RST, spmb_pkg::FRAME_HEIGHT_RST,
			spmb_pkg::PATTERN_WIDTH_RST, spmb_pkg::PATTERN_HEIGHT_RST,
			spmb_pkg::EFFECT_ALPHA_RST, spmb_pkg::RESULT_KEEP_RST};
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		feed_if.valid       = 1'b0;
		feed_if.command     = spmb_pkg::CMD_LOAD;
		feed_if.texel_index = '0;
		feed_if.cur_b       = '0;
		feed_if.cur_g       = '0;
		feed_if.cur_r       = '0;
		feed_if.bg_b        = '0;
		feed_if.bg_g        = '0;
		feed_if.bg_r        = '0;
		feed_if.mask        = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed_cases();
		test_random_phases();
		test_quiet_stretch();
		test_backpressure();
		wait_idle();
		repeat (20) @(posedge clk);

		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
